// File: hdl/scc_pkg.sv
// Package for the strongly connected components block.
// Holds sizes, operation codes, payload structs and the control/status structs.
// No dependencies.
package scc_pkg;

    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int EDGE_W    = $clog2(MAX_EDGES);
    localparam int HELD_W    = $clog2(MAX_EDGES + 1);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] src_node;
        logic [5:0] dst_node;
    } t_in_beat;

    typedef struct packed {
        logic [5:0] node_index;
        logic [5:0] component_id;
        logic [6:0] component_total;
        logic       edge_overflow;
        logic       last;
    } t_out_beat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_pass;   // clear marks, load outer counter for a pass
        logic forward;      // pass one when high
        logic outer_step;   // examine the next outer candidate
        logic edge_fetch;   // issue an edge store read for the top frame
        logic edge_eval;    // evaluate the fetched edge
        logic emit_start;   // reset the emit counter
        logic emit_step;    // present one result and advance
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic outer_done;   // no more outer candidates
        logic stack_empty;  // the walk has returned to the outer loop
        logic emit_done;    // last result has been presented
    } t_status;

endpackage

// File: hdl/scc_ctrl.sv
// Controller state machine of the strongly connected components block.
// Sequences loads, the two search passes and the result emission.
// Depends on scc_pkg.
module scc_ctrl import scc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_beat i_in_data,
    output logic     o_in_ready,
    input  logic     i_out_free,
    output t_cmd     o_cmd,
    input  t_status  i_status
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_OUTER = 7'b0000100,
        S_FETCH = 7'b0001000,
        S_EVAL  = 7'b0010000,
        S_EMIT0 = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_fwd, n_fwd;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_fwd   = r_fwd;
        o_cmd   = '0;
        o_cmd.forward = r_fwd;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_data.operation == OP_RUN) begin
                    n_state = S_START;
                    n_fwd   = 1'b1;
                end
            end
            S_START: begin
                o_cmd.start_pass = 1'b1;
                n_state = S_OUTER;
            end
            S_OUTER: begin
                if (i_status.outer_done) begin
                    if (r_fwd) begin
                        n_fwd   = 1'b0;
                        n_state = S_START;
                    end else begin
                        n_state = S_EMIT0;
                    end
                end else begin
                    o_cmd.outer_step = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (i_status.stack_empty) begin
                    n_state = S_OUTER;
                end else begin
                    o_cmd.edge_fetch = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.edge_eval = 1'b1;
                n_state = S_FETCH;
            end
            S_EMIT0: begin
                o_cmd.emit_start = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_cmd.emit_step = 1'b1;
                    if (i_status.emit_done) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fwd   <= 1'b1;
        end else begin
            r_state <= n_state;
            r_fwd   <= n_fwd;
        end
    end

endmodule

// File: hdl/scc_datapath.sv
// Datapath of the strongly connected components block: edge store, marks,
// finish order, walk stack, component labels and the output register.
// Depends on scc_pkg.
module scc_datapath import scc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [6:0] i_cfg_data,
    input  logic      i_in_accept,
    input  t_in_beat  i_in_data,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output logic      o_out_free,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    // Edge store: one memory holding source and destination side by side.
    logic [11:0] r_edge_mem [MAX_EDGES];
    logic [11:0] r_edge_rd;
    logic [HELD_W-1:0] r_held;
    logic r_ovf;
    logic [6:0] r_ncfg;
    logic [CNT_W-1:0] w_n;

    // Per-run storage.
    logic [MAX_NODES-1:0] r_mark;
    logic [NODE_W-1:0] r_finish [MAX_NODES];
    logic [NODE_W-1:0] r_comp [MAX_NODES];
    logic [NODE_W-1:0] r_stk_node [MAX_NODES];
    logic [HELD_W-1:0] r_stk_pos [MAX_NODES];
    logic [CNT_W-1:0] r_depth;
    logic [CNT_W-1:0] r_fin_cnt;
    logic [CNT_W-1:0] r_outer;
    logic [6:0] r_comp_cnt;
    logic [NODE_W-1:0] r_top_node;
    logic [HELD_W-1:0] r_top_pos;
    logic [NODE_W-1:0] r_fin_rd;
    logic [CNT_W-1:0] r_emit;
    logic [CNT_W-1:0] w_emit_next;
    logic [NODE_W-1:0] r_comp_rd;
    logic r_ov;
    t_out_beat r_od;

    always_comb begin
        if (r_ncfg == 7'd0) w_n = CNT_W'(1);
        else if (r_ncfg > 7'(MAX_NODES)) w_n = CNT_W'(MAX_NODES);
        else w_n = CNT_W'(r_ncfg);
    end

    // Edge loading and clearing.
    logic w_add_ok;
    assign w_add_ok = (r_held < HELD_W'(MAX_EDGES)) &&
                      ({1'b0, i_in_data.src_node} < w_n) &&
                      ({1'b0, i_in_data.dst_node} < w_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_ovf  <= 1'b0;
            r_ncfg <= 7'd64;
        end else begin
            if (i_cfg_we) r_ncfg <= i_cfg_data;
            if (i_in_accept && i_in_data.operation == OP_ADD) begin
                if (w_add_ok) r_held <= r_held + 1'b1;
                else r_ovf <= 1'b1;
            end else if (i_in_accept && i_in_data.operation == OP_CLEAR) begin
                r_held <= '0;
                r_ovf  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_accept && i_in_data.operation == OP_ADD && w_add_ok)
            r_edge_mem[r_held[EDGE_W-1:0]] <= {i_in_data.src_node, i_in_data.dst_node};
    end

    // Edge read for the top frame; the position is past the end when no edge is left.
    logic w_pos_ok;
    assign w_pos_ok = r_top_pos < r_held;
    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_fetch) r_edge_rd <= r_edge_mem[r_top_pos[EDGE_W-1:0]];
    end

    // Outer candidate: pass one counts up, pass two reads finish order backwards.
    logic [NODE_W-1:0] w_cand;
    assign w_cand = i_cmd.forward ? r_outer[NODE_W-1:0] : r_fin_rd;
    always_ff @(posedge i_clk) begin
        r_fin_rd <= r_finish[NODE_W'(r_outer - 1'b1)];
    end

    logic r_pos_ok;
    logic [NODE_W-1:0] w_from, w_to;
    assign w_from = i_cmd.forward ? r_edge_rd[11:6] : r_edge_rd[5:0];
    assign w_to   = i_cmd.forward ? r_edge_rd[5:0]  : r_edge_rd[11:6];

    logic w_push;
    assign w_push = r_pos_ok && w_from == r_top_node && ({1'b0, w_from} < w_n) &&
                    ({1'b0, w_to} < w_n) && !r_mark[w_to];

    logic w_cand_go;
    assign w_cand_go = i_cmd.forward ? !r_mark[w_cand] :
                       (({1'b0, w_cand} < w_n) && !r_mark[w_cand]);

    assign o_status.outer_done  = i_cmd.forward ? (r_outer == w_n) : (r_outer == '0);
    assign o_status.stack_empty = (r_depth == '0);
    assign o_status.emit_done   = (r_emit + 1'b1 == w_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_fin_cnt <= '0;
            r_outer <= '0;
            r_comp_cnt <= '0;
            r_pos_ok <= 1'b0;
        end else begin
            if (i_cmd.edge_fetch) r_pos_ok <= w_pos_ok;
            if (i_cmd.start_pass) begin
                r_mark  <= '0;
                r_depth <= '0;
                if (i_cmd.forward) begin
                    r_outer <= '0;
                    r_fin_cnt <= '0;
                end else begin
                    r_outer <= r_fin_cnt;
                    r_comp_cnt <= '0;
                end
            end
            if (i_cmd.outer_step) begin
                r_outer <= i_cmd.forward ? r_outer + 1'b1 : r_outer - 1'b1;
                if (w_cand_go) begin
                    r_mark[w_cand] <= 1'b1;
                    if (!i_cmd.forward) begin
                        r_comp[w_cand] <= r_comp_cnt[NODE_W-1:0];
                        r_comp_cnt <= r_comp_cnt + 1'b1;
                    end
                    r_stk_node[0] <= w_cand;
                    r_stk_pos[0]  <= '0;
                    r_top_node <= w_cand;
                    r_top_pos  <= '0;
                    r_depth <= CNT_W'(1);
                end
            end
            if (i_cmd.edge_fetch) r_top_pos <= r_top_pos + 1'b1;
            if (i_cmd.edge_eval) begin
                if (w_push) begin
                    // Save the resume point and enter the new node. The new
                    // frame's own position lives in r_top_pos until it pushes.
                    r_stk_pos[NODE_W'(r_depth - 1'b1)] <= r_top_pos;
                    r_mark[w_to] <= 1'b1;
                    if (!i_cmd.forward) r_comp[w_to] <= NODE_W'(r_comp_cnt - 1'b1);
                    r_stk_node[r_depth[NODE_W-1:0]] <= w_to;
                    r_top_node <= w_to;
                    r_top_pos  <= '0;
                    r_depth <= r_depth + 1'b1;
                end else if (!r_pos_ok) begin
                    // Node finished: in pass one record it in finish order; then pop.
                    if (i_cmd.forward) begin
                        r_finish[r_fin_cnt[NODE_W-1:0]] <= r_top_node;
                        r_fin_cnt <= r_fin_cnt + 1'b1;
                    end
                    r_depth <= r_depth - 1'b1;
                    r_top_node <= r_stk_node[NODE_W'(r_depth - 2'd2)];
                    r_top_pos  <= r_stk_pos[NODE_W'(r_depth - 2'd2)];
                end
            end
        end
    end

    // Emission with a one-entry output register. The label read uses the
    // counter value of the next cycle so the data lines up with r_emit.
    always_comb begin
        if (i_cmd.emit_start) w_emit_next = '0;
        else if (i_cmd.emit_step) w_emit_next = r_emit + 1'b1;
        else w_emit_next = r_emit;
    end

    always_ff @(posedge i_clk) begin
        r_comp_rd <= r_comp[w_emit_next[NODE_W-1:0]];
    end

    assign o_out_free = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_emit <= '0;
        end else begin
            if (i_cmd.emit_start) r_emit <= '0;
            if (i_cmd.emit_step) begin
                r_ov <= 1'b1;
                r_od.node_index <= r_emit[NODE_W-1:0];
                r_od.component_id <= r_comp_rd;
                r_od.component_total <= r_comp_cnt;
                r_od.edge_overflow <= r_ovf;
                r_od.last <= o_status.emit_done;
                r_emit <= r_emit + 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

endmodule

// File: hdl/strongly_connected_components.sv
// Top level of the strongly connected components block.
// Joins the controller (scc_ctrl) and the datapath (scc_datapath); uses scc_pkg.
//
// Channel   Direction  Handshake            Beat
// ------    ---------  -------------------  ---------------------------
// in        input      i_in_valid/o_in_ready t_in_beat (op, src, dst)
// out       output     o_out_valid/i_out_ready t_out_beat (one per node)
// cfg       input      i_cfg_we             node_count, 7 bits
//
// A run beat walks the graph with two depth-first passes, scanning edges
// through the single edge store read port; results then leave at one per
// cycle while the output register is free. Input is not accepted during a
// run. A stalled output holds the emission loop. Reset empties the edge store
// count and flags.
module strongly_connected_components import scc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [6:0] i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_out_free;

    scc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_out_free (w_out_free),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    scc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_accept (i_in_valid && o_in_ready),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_free  (w_out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: tb/tb_strongly_connected_components.sv
// Testbench for the strongly connected components block.
// Drives edge, run and clear beats, predicts the component labels with its own
// two-pass search model, and checks every result beat. Depends on scc_pkg.
`timescale 1ns / 1ps

module tb_strongly_connected_components;
    import scc_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic [6:0] i_cfg_data;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out_data;

    strongly_connected_components uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Model state: our own copy of the edge store and the register.
    logic [5:0] model_src [MAX_EDGES];
    logic [5:0] model_dst [MAX_EDGES];
    int         model_held;
    bit         model_overflow;
    logic [6:0] model_node_count;

    // Expected result beats, oldest first.
    t_out_beat  pending_labels [$];

    int  error_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  long_holdoff;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout: this limit lies far above the length of the whole test.
    initial begin
        #20_000_000;
        $display("** strongly_connected_components: FAILED **");
        $finish;
    end

    function automatic int nodes_active();
        if (model_node_count < 1) return 1;
        if (model_node_count > MAX_NODES) return MAX_NODES;
        return model_node_count;
    endfunction

    // Depth-first search with an explicit frame stack, forward over src->dst
    // or backward over dst->src, visiting each node's edges in load order.
    task automatic search_from(input int start, input bit forward, input int n,
                               inout bit marks [MAX_NODES], inout int order [MAX_NODES],
                               inout int finished, inout int label [MAX_NODES],
                               input int comp);
        int frame_node [MAX_NODES];
        int frame_pos  [MAX_NODES];
        int depth;
        int top;
        int pos;
        int from;
        int to;
        bit pushed;
        marks[start] = 1'b1;
        if (!forward) label[start] = comp;
        frame_node[0] = start;
        frame_pos[0] = 0;
        depth = 1;
        while (depth > 0) begin
            top = depth - 1;
            pos = frame_pos[top];
            pushed = 1'b0;
            while (pos < model_held && !pushed) begin
                from = forward ? model_src[pos] : model_dst[pos];
                to   = forward ? model_dst[pos] : model_src[pos];
                pos++;
                if (from == frame_node[top] && from < n && to < n && !marks[to]) begin
                    frame_pos[top] = pos;
                    if (depth < MAX_NODES) begin
                        marks[to] = 1'b1;
                        if (!forward) label[to] = comp;
                        frame_node[depth] = to;
                        frame_pos[depth] = 0;
                        depth++;
                    end
                    pushed = 1'b1;
                end
            end
            if (!pushed) begin
                if (forward && finished < MAX_NODES) begin
                    order[finished] = frame_node[top];
                    finished++;
                end
                depth--;
            end
        end
    endtask

    // Applies one accepted beat to the model and queues the results it causes.
    task automatic predict_components(input t_in_beat beat);
        bit marks [MAX_NODES];
        int order [MAX_NODES];
        int label [MAX_NODES];
        int n;
        int finished;
        int comp;
        int v;
        t_out_beat r;
        n = nodes_active();
        finished = 0;
        comp = 0;
        case (beat.operation)
            OP_ADD: begin
                if (model_held >= MAX_EDGES || beat.src_node >= n || beat.dst_node >= n) begin
                    model_overflow = 1'b1;
                end else begin
                    model_src[model_held] = beat.src_node;
                    model_dst[model_held] = beat.dst_node;
                    model_held++;
                end
            end
            OP_CLEAR: begin
                model_held = 0;
                model_overflow = 1'b0;
            end
            OP_RUN: begin
                foreach (marks[i]) marks[i] = 1'b0;
                foreach (label[i]) label[i] = 0;
                for (int i = 0; i < n; i++)
                    if (!marks[i]) search_from(i, 1'b1, n, marks, order, finished, label, 0);
                foreach (marks[i]) marks[i] = 1'b0;
                for (int i = finished; i > 0; i--) begin
                    v = order[i - 1];
                    if (v < n && !marks[v]) begin
                        search_from(v, 1'b0, n, marks, order, finished, label, comp);
                        comp++;
                    end
                end
                for (int i = 0; i < n; i++) begin
                    r.node_index      = 6'(i);
                    r.component_id    = 6'(label[i]);
                    r.component_total = 7'(comp);
                    r.edge_overflow   = model_overflow;
                    r.last            = (i + 1 == n);
                    pending_labels    = {pending_labels, r};
                end
            end
            default: ;
        endcase
    endtask

    // Offers one beat, with a random idle gap first, and waits for acceptance.
    // Valid stays high after acceptance; the next gap, the next beat or the
    // drain drops or replaces it at that same edge.
    task automatic send_beat(input logic [1:0] op, input logic [5:0] src,
                             input logic [5:0] dst);
        t_in_beat beat;
        beat.operation = op;
        beat.src_node  = src;
        beat.dst_node  = dst;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        predict_components(beat);
    endtask

    // Waits until every expected beat has been seen, then a short settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_labels.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_node_count(input logic [6:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_node_count = value;
    endtask

    // Receiver: random stalls, plus a long hold-off counted in cycles.
    always @(posedge i_clk) begin
        if (long_holdoff) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Checks each accepted result beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_labels.size() == 0) begin
                $display("%0t: unexpected result beat %p", $time, o_out_data);
                error_count++;
            end else begin
                want = pending_labels.pop_front();
                if (o_out_data !== want) begin
                    $display("%0t: result mismatch expected %p actual %p",
                             $time, want, o_out_data);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed();
        // Extremes of the fields at the full node count.
        send_beat(OP_ADD, 6'd0, 6'd63);
        send_beat(OP_ADD, 6'd63, 6'd0);
        send_beat(OP_ADD, 6'd1, 6'd2);
        send_beat(OP_ADD, 6'd2, 6'd1);
        send_beat(OP_ADD, 6'd2, 6'd2);
        send_beat(OP_RUN, 6'd0, 6'd0);
        // An unused operation does nothing.
        send_beat(OP_SPARE, 6'd63, 6'd63);
        send_beat(OP_CLEAR, 6'd0, 6'd0);
        send_beat(OP_RUN, 6'd21, 6'd42);
        // A small graph: edges naming nodes out of range are dropped.
        write_node_count(7'd4);
        send_beat(OP_ADD, 6'd0, 6'd1);
        send_beat(OP_ADD, 6'd1, 6'd0);
        send_beat(OP_ADD, 6'd3, 6'd4);
        send_beat(OP_ADD, 6'd2, 6'd3);
        send_beat(OP_RUN, 6'd0, 6'd0);
        // Stale edges once the count goes down.
        write_node_count(7'd2);
        send_beat(OP_RUN, 6'd0, 6'd0);
        // Zero acts as one node, above the maximum acts as the maximum.
        write_node_count(7'd0);
        send_beat(OP_RUN, 6'd0, 6'd0);
        write_node_count(7'd127);
        send_beat(OP_ADD, 6'd62, 6'd63);
        send_beat(OP_RUN, 6'd0, 6'd0);
        send_beat(OP_CLEAR, 6'd0, 6'd0);
        drain_results();
    endtask

    task automatic test_store_full();
        // Fill the store past capacity so the sticky overflow sets.
        write_node_count(7'd8);
        send_beat(OP_CLEAR, 6'd0, 6'd0);
        for (int i = 0; i < MAX_EDGES + 3; i++)
            send_beat(OP_ADD, 6'($urandom_range(7)), 6'($urandom_range(7)));
        send_beat(OP_RUN, 6'd0, 6'd0);
        send_beat(OP_CLEAR, 6'd0, 6'd0);
        drain_results();
    endtask

    // Random graphs: mostly valid edges followed by a run, some noise.
    task automatic test_random(input int beats);
        int n;
        int r;
        for (int i = 0; i < beats; i++) begin
            n = nodes_active();
            r = $urandom_range(99);
            if (r < 70) begin
                send_beat(OP_ADD, 6'($urandom_range(n - 1)), 6'($urandom_range(n - 1)));
            end else if (r < 80) begin
                send_beat(OP_ADD, 6'($urandom), 6'($urandom));
            end else if (r < 92) begin
                send_beat(OP_RUN, 6'($urandom), 6'($urandom));
            end else if (r < 97) begin
                send_beat(OP_CLEAR, 6'($urandom), 6'($urandom));
            end else begin
                send_beat(OP_SPARE, 6'($urandom), 6'($urandom));
            end
        end
        send_beat(OP_RUN, 6'd0, 6'd0);
        drain_results();
    endtask

    task automatic test_backpressure();
        // Hold the output off while runs and edges keep coming.
        long_holdoff = 1'b1;
        fork
            begin
                send_beat(OP_RUN, 6'd0, 6'd0);
                send_beat(OP_ADD, 6'd1, 6'd0);
                send_beat(OP_RUN, 6'd0, 6'd0);
            end
            begin
                repeat (400) @(posedge i_clk);
                long_holdoff = 1'b0;
            end
        join
        drain_results();
    endtask

    initial begin
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_holdoff = 1'b0;
        model_held = 0;
        model_overflow = 1'b0;
        model_node_count = 7'd64;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_store_full();
        write_node_count(7'd12);
        test_random(30);
        send_idle_pct = 65;
        write_node_count(7'd5);
        test_random(30);
        send_idle_pct = 0;
        recv_stall_pct = 65;
        write_node_count(7'd64);
        test_random(30);
        send_idle_pct = 8;
        recv_stall_pct = 8;
        write_node_count(7'd1);
        test_random(10);
        write_node_count(7'd20);
        test_random(20);
        recv_stall_pct = 0;
        test_backpressure();
        drain_results();

        if (error_count == 0) begin
            $display("** strongly_connected_components: PASSED **");
        end else begin
            $display("** strongly_connected_components: FAILED **");
        end
        $finish;
    end

endmodule
